// File: rtl/core/nt_pkg.sv
package nt_pkg;

    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int VIEW_DEPTH_DEF   = 8;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] FUNC_UPSERT = 2'd0;
    localparam logic [1:0] FUNC_PRUNE  = 2'd1;
    localparam logic [1:0] FUNC_SNAP   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [1:0] KIND_FRIEND = 2'd0;
    localparam logic [1:0] KIND_ENEMY  = 2'd1;
    localparam logic [1:0] KIND_SUM    = 2'd2;

    localparam logic [1:0] REG_OWN_TEAM = 2'd0;
    localparam logic [1:0] REG_MAX_AGE  = 2'd1;

    localparam logic [31:0] MAX_AGE_RESET = 32'd1000;

    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] neighbor_mac;
        logic [7:0]  neighbor_team;
        logic [31:0] seen_time;
        logic [63:0] payload;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] entry_mac;
        logic [7:0]  entry_team;
        logic [31:0] entry_seen;
        logic [63:0] entry_payload;
        logic [3:0]  friend_count;
        logic [3:0]  enemy_count;
        logic [31:0] snapshot_time;
        logic        last;
    } result_t;

    // command handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] mac;
        logic [7:0]  team;
        logic [31:0] seen;
        logic [63:0] payload;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  own_team;
        logic [31:0] max_age;
    } cfg_t;

endpackage

// File: rtl/core/nt_ram.sv
module nt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/nt_queue.sv
module nt_queue
    import nt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          buf_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = count_reg == CW'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/nt_front.sv
module nt_front
    import nt_pkg::*;
#(
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg,
    output logic        push,
    output cmd_t        push_data,
    input  logic        q_full
);

    logic [7:0]  own_team_reg;
    logic [31:0] max_age_reg;

    assign cfg_ready    = 1'b1;
    assign cfg.own_team = own_team_reg;
    assign cfg.max_age  = max_age_reg;

    assign item_ready = !q_full;
    // drop the unused code at the door
    assign push = item_valid && !q_full && (item.func != FUNC_NONE);

    always_comb
    begin
        push_data.op      = item.func;
        push_data.mac     = item.neighbor_mac;
        push_data.team    = item.neighbor_team;
        push_data.seen    = item.seen_time;
        push_data.payload = 64'(item.payload[PAYLOAD_BITS-1:0]);
        push_data.now     = item.now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_team_reg <= '0;
            max_age_reg  <= MAX_AGE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OWN_TEAM: own_team_reg <= cfg_data[7:0];
                REG_MAX_AGE:  max_age_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule

// File: rtl/core/nt_back.sv
module nt_back
    import nt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int VIEW_DEPTH   = VIEW_DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_empty,
    input  cmd_t    q_data,
    output logic    pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(VIEW_DEPTH + 1);
    localparam int RW = 88 + PAYLOAD_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    logic [1:0]             state_reg;
    cmd_t                   cmd_reg;
    logic [IW:0]            cnt_reg;
    logic                   ev_valid_reg;
    logic [IW-1:0]          ev_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   match_hit_reg;
    logic [IW-1:0]          match_idx_reg;
    logic                   empty_hit_reg;
    logic [IW-1:0]          empty_idx_reg;
    logic [IW-1:0]          min_idx_reg;
    logic [31:0]            min_seen_reg;
    logic [CW-1:0]          fc_reg;
    logic [CW-1:0]          ec_reg;
    logic                   res_valid_reg;
    result_t                res_reg;

    logic [RW-1:0]           rdata;
    logic [47:0]             rd_mac;
    logic [7:0]              rd_team;
    logic [31:0]             rd_seen;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic                    ev_occ;
    logic                    is_friend;
    logic                    emit_req;
    logic                    out_free;
    logic                    stall;
    logic                    scan_go;
    logic                    re;
    logic                    eval;
    logic                    ev_last;
    logic                    res_set;
    logic [IW-1:0]           slot_sel;
    logic [31:0]             age;

    assign rd_mac     = rdata[RW-1 -: 48];
    assign rd_team    = rdata[PAYLOAD_BITS+39 -: 8];
    assign rd_seen    = rdata[PAYLOAD_BITS+31 -: 32];
    assign rd_payload = rdata[PAYLOAD_BITS-1:0];

    assign ev_occ    = valid_reg[ev_idx_reg];
    assign is_friend = rd_team == cfg.own_team;
    assign age       = cmd_reg.now - rd_seen;
    assign out_free  = !res_valid_reg || res_ready;

    always_comb
    begin
        emit_req = 1'b0;
        if (ev_valid_reg && ev_occ && cmd_reg.op == FUNC_SNAP)
        begin
            emit_req = is_friend ? (fc_reg < CW'(VIEW_DEPTH)) : (ec_reg < CW'(VIEW_DEPTH));
        end
    end

    // hold the scan while a listed entry waits for the output register
    assign stall   = emit_req && !out_free;
    assign scan_go = (state_reg == ST_SCAN) && !stall;
    assign re      = scan_go && (cnt_reg < (IW+1)'(TABLE_DEPTH));
    assign eval    = scan_go && ev_valid_reg;
    assign ev_last = ev_idx_reg == IW'(TABLE_DEPTH - 1);
    assign pop     = (state_reg == ST_IDLE) && !q_empty;
    assign res_set = (eval && emit_req) || (state_reg == ST_SUM && out_free);

    always_comb
    begin
        if (match_hit_reg)
        begin
            slot_sel = match_idx_reg;
        end
        else if (empty_hit_reg)
        begin
            slot_sel = empty_idx_reg;
        end
        else
        begin
            slot_sel = min_idx_reg;
        end
    end

    nt_ram #(
        .WIDTH(RW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (state_reg == ST_WRITE),
        .waddr(slot_sel),
        .wdata({cmd_reg.mac, cmd_reg.team, cmd_reg.seen, cmd_reg.payload[PAYLOAD_BITS-1:0]}),
        .re   (re),
        .raddr(cnt_reg[IW-1:0]),
        .rdata(rdata)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_data;
        end
        if (eval && emit_req)
        begin
            res_reg.kind          <= is_friend ? KIND_FRIEND : KIND_ENEMY;
            res_reg.entry_mac     <= rd_mac;
            res_reg.entry_team    <= rd_team;
            res_reg.entry_seen    <= rd_seen;
            res_reg.entry_payload <= 64'(rd_payload);
            res_reg.friend_count  <= '0;
            res_reg.enemy_count   <= '0;
            res_reg.snapshot_time <= cmd_reg.now;
            res_reg.last          <= 1'b0;
        end
        else if (state_reg == ST_SUM && out_free)
        begin
            res_reg.kind          <= KIND_SUM;
            res_reg.entry_mac     <= '0;
            res_reg.entry_team    <= '0;
            res_reg.entry_seen    <= '0;
            res_reg.entry_payload <= '0;
            res_reg.friend_count  <= 4'(fc_reg);
            res_reg.enemy_count   <= 4'(ec_reg);
            res_reg.snapshot_time <= cmd_reg.now;
            res_reg.last          <= 1'b1;
        end
        if (eval)
        begin
            if (ev_occ && rd_mac == cmd_reg.mac && !match_hit_reg)
            begin
                match_idx_reg <= ev_idx_reg;
            end
            if (!ev_occ && !empty_hit_reg)
            begin
                empty_idx_reg <= ev_idx_reg;
            end
            if (ev_idx_reg == '0 || rd_seen < min_seen_reg)
            begin
                min_idx_reg  <= ev_idx_reg;
                min_seen_reg <= rd_seen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            ev_idx_reg    <= '0;
            valid_reg     <= '0;
            match_hit_reg <= 1'b0;
            empty_hit_reg <= 1'b0;
            fc_reg        <= '0;
            ec_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_set || (res_valid_reg && !res_ready);
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg     <= ST_SCAN;
                        cnt_reg       <= '0;
                        ev_valid_reg  <= 1'b0;
                        match_hit_reg <= 1'b0;
                        empty_hit_reg <= 1'b0;
                        fc_reg        <= '0;
                        ec_reg        <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_go)
                    begin
                        if (re)
                        begin
                            cnt_reg      <= cnt_reg + 1'b1;
                            ev_valid_reg <= 1'b1;
                            ev_idx_reg   <= cnt_reg[IW-1:0];
                        end
                        else
                        begin
                            ev_valid_reg <= 1'b0;
                        end
                    end
                    if (eval)
                    begin
                        if (ev_occ && rd_mac == cmd_reg.mac)
                        begin
                            match_hit_reg <= 1'b1;
                        end
                        if (!ev_occ)
                        begin
                            empty_hit_reg <= 1'b1;
                        end
                        if (cmd_reg.op == FUNC_PRUNE && ev_occ && age > cfg.max_age)
                        begin
                            valid_reg[ev_idx_reg] <= 1'b0;
                        end
                        if (emit_req)
                        begin
                            if (is_friend)
                            begin
                                fc_reg <= fc_reg + 1'b1;
                            end
                            else
                            begin
                                ec_reg <= ec_reg + 1'b1;
                            end
                        end
                        if (ev_last)
                        begin
                            case (cmd_reg.op)
                                FUNC_UPSERT: state_reg <= ST_WRITE;
                                FUNC_SNAP:   state_reg <= ST_SUM;
                                default:     state_reg <= ST_IDLE;
                            endcase
                        end
                    end
                end
                ST_WRITE:
                begin
                    // a zero time stamp leaves the slot empty
                    valid_reg[slot_sel] <= cmd_reg.seen != '0;
                    state_reg           <= ST_IDLE;
                end
                ST_SUM:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_write_is_upsert: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> cmd_reg.op == FUNC_UPSERT)
        else $error("table write outside an upsert");

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> state_reg == ST_SCAN)
        else $error("pending read data outside a scan");

    a_last_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.last |-> res_reg.kind == KIND_SUM)
        else $error("closing word without summary kind");

    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE && cmd_reg.seen != '0 |=> valid_reg[$past(slot_sel)])
        else $error("written slot not marked occupied");

endmodule

// File: rtl/core/neighbor_table_upsert_age.sv
// Neighbor table of TABLE_DEPTH slots keyed by a 48-bit address. Each command
// (upsert, prune, snapshot) makes one pass over the table RAM, one slot per
// cycle through the single read port of the table RAM; a snapshot pass holds
// whenever a listed word waits at the output. A two-word command queue sits
// between the input side and the table engine, so new commands are taken while
// a pass runs. Occupancy lives in per-slot flags cleared at reset, so no
// clearing pass is needed. Configuration is to be written through the cfg
// channel while the block is idle; the block itself does not enforce this.
module neighbor_table_upsert_age
    import nt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int VIEW_DEPTH   = VIEW_DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg;
    logic push;
    cmd_t push_data;
    logic q_full;
    logic q_empty;
    logic pop;
    cmd_t q_data;

    nt_front #(
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    nt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (pop),
        .pop_data (q_data),
        .empty    (q_empty)
    );

    nt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VIEW_DEPTH  (VIEW_DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .pop      (pop),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

endmodule
